[design/card_whitelist_door_controller_unit_defines.svh]
// ----------------------------------------------------------------------------
// Card whitelist door controller - assertion macros
// Concurrent check wrappers; they compile to nothing under SYNTHESIS.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef CARD_WHITELIST_DOOR_CONTROLLER_UNIT_DEFINES_SVH
`define CARD_WHITELIST_DOOR_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CWDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define CWDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CWDC_ASSERT_IMP(lbl, ante, cons)
`define CWDC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/cwdc_pkg.sv]
// ----------------------------------------------------------------------------
// cwdc_pkg
// Shared types, codes and helpers of the card whitelist door controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cwdc_pkg;

  localparam int CWDC_TABLE_ENTRIES = 16;
  localparam int CWDC_MAX_UID_BYTES = 10;

  localparam int UID_LOW_W = 64;
  localparam int UID_HIGH_W = 16;
  localparam int UID_LEN_W = 4;
  localparam int HOLDER_W = 16;
  localparam int TICK_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DOOR_OPEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE = 2'd1;

  localparam logic [TICK_W-1:0] DOOR_OPEN_RST = 8'd2;
  localparam logic [TICK_W-1:0] MESSAGE_RST = 8'd3;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PRESENT = 2'd2,
    MODE_TICK = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    STAT_ADDED = 4'd0,
    STAT_TOO_LONG = 4'd1,
    STAT_DUPLICATE = 4'd2,
    STAT_FULL = 4'd3,
    STAT_REMOVED = 4'd4,
    STAT_NOT_FOUND = 4'd5,
    STAT_GRANTED = 4'd6,
    STAT_DENIED = 4'd7,
    STAT_TICK = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SHOW_HOLDER = 2'd1,
    ACT_SHOW_DENIED = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_HOLDER = 2'd1,
    KIND_DENIED = 2'd2
  } kind_t;

  // masked card identifier as stored and compared
  typedef struct packed {
    logic [UID_LOW_W-1:0] uid;
    logic [UID_HIGH_W-1:0] top;
    logic [UID_LEN_W-1:0] len;
  } key_t;

  typedef struct packed {
    key_t key;
    logic [HOLDER_W-1:0] holder;
  } entry_t;

  // sequencer -> table
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } tbl_cmd_t;

  // table -> sequencer, about the entry compared this cycle
  typedef struct packed {
    logic hit;
    logic free;
  } tbl_stat_t;

  // keep the low len bytes of the identifier
  function automatic logic [UID_LOW_W-1:0] low_mask(input logic [UID_LEN_W-1:0] len);
    logic [UID_LOW_W-1:0] m;
    m = '0;
    for (int b = 0; b < UID_LOW_W / 8; b++) begin
      m[8*b +: 8] = (len > UID_LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [UID_HIGH_W-1:0] high_mask(input logic [UID_LEN_W-1:0] len);
    logic [UID_HIGH_W-1:0] m;
    m = '0;
    for (int b = 0; b < UID_HIGH_W / 8; b++) begin
      m[8*b +: 8] = (len > UID_LEN_W'(UID_LOW_W / 8 + b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == {TICK_W{1'b1}}) ? v : v + TICK_W'(1);
  endfunction

endpackage

`default_nettype wire

[design/cwdc_in_if.sv]
// ----------------------------------------------------------------------------
// cwdc_in_if
// Request channel: valid/ready plus one card or tick item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwdc_in_if import cwdc_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [UID_LOW_W-1:0] uid_low;
  logic [UID_HIGH_W-1:0] uid_high;
  logic [UID_LEN_W-1:0] uid_len;
  logic [HOLDER_W-1:0] holder_id;

  modport source (output valid, mode, uid_low, uid_high, uid_len, holder_id, input ready);
  modport sink (input valid, mode, uid_low, uid_high, uid_len, holder_id, output ready);
endinterface

`default_nettype wire

[design/cwdc_out_if.sv]
// ----------------------------------------------------------------------------
// cwdc_out_if
// Result channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwdc_out_if import cwdc_pkg::*; ();
  logic valid;
  logic ready;
  logic [3:0] status;
  logic door_unlocked;
  logic [1:0] display_action;
  logic [HOLDER_W-1:0] shown_holder;

  modport source (output valid, status, door_unlocked, display_action, shown_holder,
                  input ready);
  modport sink (input valid, status, door_unlocked, display_action, shown_holder,
                output ready);
endinterface

`default_nettype wire

[design/cwdc_table.sv]
// ----------------------------------------------------------------------------
// cwdc_table
// Whitelist storage: entry memory, per-entry valid flops and the one key
// comparator that the sequencer sweeps across the table.
// ----------------------------------------------------------------------------
`default_nettype none

module cwdc_table import cwdc_pkg::*; #(
  parameter int TABLE_ENTRIES = CWDC_TABLE_ENTRIES,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tbl_cmd_t         cmd,
  input  wire logic [IDX_W-1:0] rd_idx,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire entry_t           wr_entry,
  input  wire key_t             key,
  output tbl_stat_t             stat,
  output logic [IDX_W-1:0]      cmp_idx,
  output logic [HOLDER_W-1:0]   cmp_holder
);

  entry_t mem_r [TABLE_ENTRIES];
  entry_t rd_q_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic rd_vld_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  // storage, no reset: entries are only trusted behind their valid bit
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[wr_idx] <= wr_entry;
    end
    if (cmd.rd) begin
      rd_q_r <= mem_r[rd_idx];
      rd_idx_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.wr) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (cmd.clr) begin
        valid_r[wr_idx] <= 1'b0;
      end
    end
  end

  // length and masked bytes compared in one go
  assign stat.hit = rd_vld_r && valid_r[rd_idx_r] && (rd_q_r.key == key);
  assign stat.free = rd_vld_r && !valid_r[rd_idx_r];
  assign cmp_idx = rd_idx_r;
  assign cmp_holder = rd_q_r.holder;

endmodule

`default_nettype wire

[design/card_whitelist_door_controller_unit.sv]
// ----------------------------------------------------------------------------
// card_whitelist_door_controller_unit
// Card whitelist with door lock and display bookkeeping.
// ----------------------------------------------------------------------------
// Takes add, remove, present and one-second tick items, one at a time, and
// returns exactly one result per item. Add, remove and present sweep the
// whole table through a single key comparator, one entry per cycle from the
// entry memory's registered read port, then a drain step for the last entry
// and the final step. Ticks and over-long identifiers skip the sweep and go
// straight to the final step. in_ch.ready is high
// only while the sequencer is idle; a finished result sits in the output
// register until taken, and the next input can be taken meanwhile. A new
// result waits in the final step while the previous one is still unclaimed.
// Configuration writes (door_open_seconds at index 0, message_seconds at
// index 1) land on the clock edge where cfg_we is high; other indexes are
// ignored. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "card_whitelist_door_controller_unit_defines.svh"

module card_whitelist_door_controller_unit import cwdc_pkg::*; #(
  parameter int TABLE_ENTRIES = CWDC_TABLE_ENTRIES,
  parameter int MAX_UID_BYTES = CWDC_MAX_UID_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cwdc_in_if.sink                    in_ch,
  cwdc_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [UID_LEN_W-1:0] MAX_LEN = UID_LEN_W'(MAX_UID_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // sequencer
  state_t state_r;
  mode_t mode_r;
  key_t key_r;
  logic [HOLDER_W-1:0] holder_r;
  logic too_long_r;
  logic [IDX_W-1:0] idx_r;

  // sweep results
  logic found_r;
  logic [IDX_W-1:0] match_idx_r;
  logic [HOLDER_W-1:0] match_holder_r;
  logic free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  // door and display
  logic unlocked_r, unlocked_nxt;
  logic [TICK_W-1:0] door_ticks_r, door_ticks_nxt;
  kind_t disp_kind_r, disp_kind_nxt;
  logic [TICK_W-1:0] disp_ticks_r, disp_ticks_nxt;
  logic [HOLDER_W-1:0] last_holder_r, last_holder_nxt;
  logic last_granted_r, last_granted_nxt;

  // configuration
  logic [TICK_W-1:0] cfg_door_r;
  logic [TICK_W-1:0] cfg_msg_r;

  // output register
  logic out_valid_r;
  status_t out_status_r;
  logic out_door_r;
  action_t out_action_r;
  logic [HOLDER_W-1:0] out_shown_r;

  // result of the item in the final step
  status_t res_status;
  action_t res_action;
  logic [HOLDER_W-1:0] res_shown;
  logic do_wr, do_clr;
  logic [TICK_W-1:0] door_inc, disp_inc;

  logic in_xfer;
  logic fin_go;
  logic [UID_LEN_W-1:0] in_len;

  tbl_cmd_t tbl_cmd;
  tbl_stat_t tbl_stat;
  logic [IDX_W-1:0] tbl_wr_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic [HOLDER_W-1:0] cmp_holder;
  entry_t wr_entry;

  assign in_len = in_ch.uid_len;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  // final step may retire only when the output register frees up
  assign fin_go = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  assign door_inc = sat_inc(door_ticks_r);
  assign disp_inc = sat_inc(disp_ticks_r);

  always_comb begin
    res_status = STAT_TICK;
    res_action = ACT_NONE;
    res_shown = '0;
    do_wr = 1'b0;
    do_clr = 1'b0;
    unlocked_nxt = unlocked_r;
    door_ticks_nxt = door_ticks_r;
    disp_kind_nxt = disp_kind_r;
    disp_ticks_nxt = disp_ticks_r;
    last_holder_nxt = last_holder_r;
    last_granted_nxt = last_granted_r;
    unique case (mode_r)
      MODE_ADD: begin
        priority if (too_long_r) begin
          res_status = STAT_TOO_LONG;
        end else if (found_r) begin
          res_status = STAT_DUPLICATE;
        end else if (!free_found_r) begin
          res_status = STAT_FULL;
        end else begin
          res_status = STAT_ADDED;
          do_wr = 1'b1;
        end
      end
      MODE_REMOVE: begin
        // an over-long key skipped the sweep, so found_r stays low
        if (found_r) begin
          res_status = STAT_REMOVED;
          do_clr = 1'b1;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      MODE_PRESENT: begin
        if (found_r) begin
          res_status = STAT_GRANTED;
          res_shown = match_holder_r;
          unlocked_nxt = 1'b1;
          door_ticks_nxt = '0;
          // same holder still on show: no redraw, timers restart anyway
          if (disp_kind_r == KIND_HOLDER && last_granted_r &&
              last_holder_r == match_holder_r) begin
            res_action = ACT_NONE;
          end else begin
            res_action = ACT_SHOW_HOLDER;
            disp_kind_nxt = KIND_HOLDER;
            last_holder_nxt = match_holder_r;
          end
          disp_ticks_nxt = '0;
          last_granted_nxt = 1'b1;
        end else begin
          res_status = STAT_DENIED;
          unlocked_nxt = 1'b0;
          door_ticks_nxt = '0;
          // denial already on show keeps its running timer
          if (disp_kind_r != KIND_DENIED) begin
            res_action = ACT_SHOW_DENIED;
            disp_kind_nxt = KIND_DENIED;
            disp_ticks_nxt = '0;
          end
          last_granted_nxt = 1'b0;
        end
      end
      MODE_TICK: begin
        res_status = STAT_TICK;
        if (unlocked_r) begin
          if (door_inc > cfg_door_r) begin
            unlocked_nxt = 1'b0;
            door_ticks_nxt = '0;
          end else begin
            door_ticks_nxt = door_inc;
          end
        end
        if (disp_kind_r != KIND_NONE) begin
          if (disp_inc > cfg_msg_r) begin
            disp_kind_nxt = KIND_NONE;
            disp_ticks_nxt = '0;
            last_holder_nxt = '0;
            res_action = ACT_CLEAR;
          end else begin
            disp_ticks_nxt = disp_inc;
          end
        end
      end
      default: begin
        res_status = STAT_TICK;
      end
    endcase
  end

  // table hookup: writes and clears share the write index
  assign tbl_cmd.rd = (state_r == ST_SCAN);
  assign tbl_cmd.wr = fin_go && do_wr;
  assign tbl_cmd.clr = fin_go && do_clr;
  assign tbl_wr_idx = do_wr ? free_idx_r : match_idx_r;
  assign wr_entry.key = key_r;
  assign wr_entry.holder = holder_r;

  cwdc_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (tbl_cmd),
    .rd_idx     (idx_r),
    .wr_idx     (tbl_wr_idx),
    .wr_entry   (wr_entry),
    .key        (key_r),
    .stat       (tbl_stat),
    .cmp_idx    (cmp_idx),
    .cmp_holder (cmp_holder)
  );

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= mode_t'(in_ch.mode);
      key_r.uid <= in_ch.uid_low & low_mask(in_len);
      key_r.top <= in_ch.uid_high & high_mask(in_len);
      key_r.len <= in_len;
      holder_r <= in_ch.holder_id;
    end
    if (tbl_stat.hit && !found_r) begin
      match_idx_r <= cmp_idx;
      match_holder_r <= cmp_holder;
    end
    if (tbl_stat.free && !free_found_r) begin
      free_idx_r <= cmp_idx;
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_door_r <= unlocked_nxt;
      out_action_r <= res_action;
      out_shown_r <= res_shown;
    end
  end

  // sequencer state and registered controls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      too_long_r <= 1'b0;
      found_r <= 1'b0;
      free_found_r <= 1'b0;
      unlocked_r <= 1'b0;
      door_ticks_r <= '0;
      disp_kind_r <= KIND_NONE;
      disp_ticks_r <= '0;
      last_holder_r <= '0;
      last_granted_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tbl_stat.hit && !found_r) begin
        found_r <= 1'b1;
      end
      if (tbl_stat.free && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_r <= '0;
            found_r <= 1'b0;
            free_found_r <= 1'b0;
            too_long_r <= (in_len > MAX_LEN);
            // ticks and over-long keys have nothing to look up
            if (mode_t'(in_ch.mode) == MODE_TICK || in_len > MAX_LEN) begin
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // last entry is compared here
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_go) begin
            unlocked_r <= unlocked_nxt;
            door_ticks_r <= door_ticks_nxt;
            disp_kind_r <= disp_kind_nxt;
            disp_ticks_r <= disp_ticks_nxt;
            last_holder_r <= last_holder_nxt;
            last_granted_r <= last_granted_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_door_r <= DOOR_OPEN_RST;
      cfg_msg_r <= MESSAGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DOOR_OPEN: cfg_door_r <= cfg_wdata;
        REG_MESSAGE: cfg_msg_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.door_unlocked = out_door_r;
  assign out_ch.display_action = out_action_r;
  assign out_ch.shown_holder = out_shown_r;

  // checks
  `CWDC_ASSERT_IMP(a_door_denied, out_valid_r && out_status_r == STAT_DENIED, !out_door_r)
  `CWDC_ASSERT_IMP(a_shown_grant, out_valid_r && out_status_r != STAT_GRANTED, out_shown_r == '0)
  `CWDC_ASSERT_IMP(a_table_quiet, out_valid_r && out_status_r <= STAT_NOT_FOUND, out_action_r == ACT_NONE)
  `CWDC_ASSERT_IMP(a_cmp_in_sweep, tbl_stat.hit || tbl_stat.free, state_r == ST_SCAN || state_r == ST_DRAIN)
  `CWDC_ASSERT_NXT(a_busy_after_xfer, in_xfer, !in_ch.ready)

endmodule

`default_nettype wire
